// ----- rtl/core/bb26_pkg.sv -----
package bb26_pkg;

    typedef enum logic [3:0] {
        ST_COLLECT,
        ST_ACC,
        ST_CONV,
        ST_WORD,
        ST_PAD,
        ST_NUM,
        ST_END
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic store_char;
        logic clear_line;
        logic start_line;
        logic acc_step;
        logic conv_step;
        logic emit_word;
        logic emit_pad;
        logic emit_num;
        logic emit_end;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_star;
        logic acc_done;
        logic conv_done;
        logic word_done;
        logic pad_done;
        logic num_done;
    } status_t;

    localparam int unsigned CONV_DEPTH = 40;
    localparam int unsigned MAX_CHARS  = 60;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_STAR  = 8'd42;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_LA    = 8'd97;
    localparam logic [7:0] CH_LZ    = 8'd122;

    // reciprocals for x / 13 and x / 5, exact for x < 2^20
    localparam logic [21:0] RECIP_13    = 22'd1290556;
    localparam logic [21:0] RECIP_5     = 22'd3355444;
    localparam int unsigned RECIP_SHIFT = 24;
    // reciprocal for n / 3, exact for n < 512
    localparam logic [7:0]  RECIP_3      = 8'd171;
    localparam int unsigned RECIP3_SHIFT = 9;

endpackage

// ----- rtl/core/bb26_ctrl.sv -----
module bb26_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic              in_is_nl,
    input  logic              out_free,
    input  bb26_pkg::status_t sts,
    output bb26_pkg::cmd_t    cmd,
    output logic              in_ready
);

    bb26_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= bb26_pkg::ST_COLLECT;
        else state_reg <= state_next;
    end

    // emit phases advance only on a cycle where the datapath command is issued
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bb26_pkg::ST_COLLECT: begin
                if (in_fire && in_is_nl && !sts.is_star) state_next = bb26_pkg::ST_ACC;
            end
            bb26_pkg::ST_ACC: if (sts.acc_done) state_next = bb26_pkg::ST_CONV;
            bb26_pkg::ST_CONV: if (sts.conv_done) state_next = bb26_pkg::ST_WORD;
            bb26_pkg::ST_WORD: if (sts.word_done && out_free) state_next = bb26_pkg::ST_PAD;
            bb26_pkg::ST_PAD: if (sts.pad_done && out_free) state_next = bb26_pkg::ST_NUM;
            bb26_pkg::ST_NUM: if (sts.num_done && out_free) state_next = bb26_pkg::ST_END;
            bb26_pkg::ST_END: if (out_free) state_next = bb26_pkg::ST_COLLECT;
            default: state_next = bb26_pkg::ST_COLLECT;
        endcase
    end

    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            bb26_pkg::ST_COLLECT: begin
                in_ready = 1'b1;
                cmd.store_char = in_fire && !in_is_nl;
                cmd.clear_line = in_fire && in_is_nl && sts.is_star;
                cmd.start_line = in_fire && in_is_nl && !sts.is_star;
            end
            bb26_pkg::ST_ACC:  cmd.acc_step = 1'b1;
            bb26_pkg::ST_CONV: cmd.conv_step = 1'b1;
            bb26_pkg::ST_WORD: cmd.emit_word = out_free;
            bb26_pkg::ST_PAD:  cmd.emit_pad = out_free;
            bb26_pkg::ST_NUM:  cmd.emit_num = out_free;
            bb26_pkg::ST_END:  cmd.emit_end = out_free;
            default: ;
        endcase
    end

endmodule

// ----- rtl/core/bb26_dp.sv -----
module bb26_dp #(
    parameter int unsigned LINE_DEPTH = 32,
    parameter int unsigned PAD_COLUMN = 22,
    parameter int unsigned ACC_BITS   = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  bb26_pkg::cmd_t    cmd,
    input  logic [7:0]        in_char,
    output bb26_pkg::status_t sts,
    output logic              out_free,
    input  logic              m_ready,
    output logic              m_valid,
    output logic [7:0]        m_out_char,
    output logic              m_last_of_line
);

    localparam int unsigned LW  = $clog2(LINE_DEPTH + 1);
    localparam int unsigned LI  = $clog2(LINE_DEPTH);
    localparam int unsigned CW  = $clog2(bb26_pkg::CONV_DEPTH + 1);
    localparam int unsigned CI  = $clog2(bb26_pkg::CONV_DEPTH);
    localparam int unsigned PW  = $clog2(PAD_COLUMN + 1);
    localparam int unsigned XW  = (LW > CW) ? LW : CW;
    // accumulator is divided in 16-bit chunks, most significant first
    localparam int unsigned NCH = (ACC_BITS + 15) / 16;
    localparam int unsigned AW  = NCH * 16;
    localparam int unsigned HW  = $clog2(NCH);

    logic [7:0]          line_mem [LINE_DEPTH];
    logic [7:0]          conv_mem [bb26_pkg::CONV_DEPTH];
    logic [7:0]          line_rd_reg;  // line_mem[idx_reg]
    logic [7:0]          conv_rd_reg;  // conv_mem[conv_len_reg - idx_reg - 1]
    logic [LW-1:0]       line_len_reg, len_reg;
    logic [7:0]          first_reg;
    logic                dec_reg;
    logic [AW-1:0]       acc_reg;
    logic [CW-1:0]       conv_len_reg;
    logic [XW-1:0]       idx_reg, idx_next;  // accumulate, word and digit index
    logic [HW-1:0]       chunk_reg;    // chunk being divided
    logic [4:0]          rem_reg;      // running remainder of the divide
    logic                busy_reg;     // divide of one digit in progress
    logic                borrow_reg;   // z digit taken, decrement pending
    logic [1:0]          grp_reg;      // digits left in current comma group
    logic                comma_reg;    // comma pending before next digit
    logic [PW-1:0]       col_reg;
    logic [5:0]          cnt_reg;      // characters emitted, excluding newline
    logic                ov_reg;
    logic [7:0]          od_reg;
    logic                ol_reg;

    logic [ACC_BITS-1:0] acc_low;
    logic [ACC_BITS-1:0] mul_acc;
    logic [ACC_BITS-1:0] acc_sum;
    logic [15:0]         div_in;
    logic [20:0]         div_t;
    logic [19:0]         div_half;
    logic [41:0]         div_prod;
    logic [15:0]         div_q;
    logic [20:0]         div_qk;
    logic [4:0]          div_rem;
    logic                conv_wr;
    logic [7:0]          conv_ch;
    logic [CW-1:0]       conv_raddr;
    logic [XW-1:0]       wlen;
    logic [XW-1:0]       nlen;
    logic [7:0]          word_ch, num_ch;
    logic                emit_ch;
    logic [7:0]          emit_d;
    logic [15:0]         lead_prod;
    logic [XW-1:0]       lead_q, lead_m;
    logic [1:0]          lead;

    assign out_free = !ov_reg || m_ready;
    assign m_valid = ov_reg;
    assign m_out_char = od_reg;
    assign m_last_of_line = ol_reg;

    always_ff @(posedge aclk) begin
        if (cmd.store_char && line_len_reg < LW'(LINE_DEPTH))
            line_mem[line_len_reg[LI-1:0]] <= in_char;
        line_rd_reg <= line_mem[idx_next[LI-1:0]];
    end

    // first character of a line is captured for star test and mode choice
    always_ff @(posedge aclk) begin
        if (cmd.store_char && line_len_reg == '0) first_reg <= in_char;
    end
    assign sts.is_star = (line_len_reg != '0) && first_reg == bb26_pkg::CH_STAR;

    always_ff @(posedge aclk) begin
        if (!aresetn) line_len_reg <= '0;
        else if (cmd.clear_line || cmd.start_line) line_len_reg <= '0;
        else if (cmd.store_char && line_len_reg < LW'(LINE_DEPTH))
            line_len_reg <= line_len_reg + 1'b1;
    end

    // accumulate: one character a cycle, acc*k + c - base
    assign acc_low = ACC_BITS'(acc_reg);
    assign mul_acc = dec_reg ? ((acc_low << 3) + (acc_low << 1))
                             : ((acc_low << 4) + (acc_low << 3) + (acc_low << 1));
    assign acc_sum = mul_acc + ACC_BITS'(line_rd_reg)
                     - (dec_reg ? ACC_BITS'(48) : ACC_BITS'(96));
    assign sts.acc_done = idx_reg >= XW'(len_reg);

    // convert: long division by 26 or 10, one 16-bit chunk a cycle.
    // t / 26 = (t >> 1) / 13 and t / 10 = (t >> 1) / 5, by reciprocal.
    assign div_in = acc_reg[{chunk_reg, 4'b0000} +: 16];
    assign div_t = {rem_reg, div_in};
    assign div_half = div_t[20:1];
    assign div_prod = 42'(div_half) * (dec_reg ? 42'(bb26_pkg::RECIP_13)
                                                : 42'(bb26_pkg::RECIP_5));
    assign div_q = div_prod[bb26_pkg::RECIP_SHIFT +: 16];
    assign div_qk = dec_reg ? ((21'(div_q) << 4) + (21'(div_q) << 3) + (21'(div_q) << 1))
                            : ((21'(div_q) << 3) + (21'(div_q) << 1));
    assign div_rem = 5'(div_t - div_qk);

    assign sts.conv_done = !busy_reg && !borrow_reg
        && (acc_reg == '0 || conv_len_reg == CW'(bb26_pkg::CONV_DEPTH));

    assign conv_wr = cmd.conv_step && !borrow_reg && !sts.conv_done && chunk_reg == '0;
    always_comb begin
        if (!dec_reg) conv_ch = bb26_pkg::CH_ZERO + 8'(div_rem);
        else if (div_rem == '0) conv_ch = bb26_pkg::CH_LZ;
        else conv_ch = bb26_pkg::CH_LA - 8'd1 + 8'(div_rem);
    end

    assign conv_raddr = conv_len_reg - CW'(idx_next) - CW'(1);
    always_ff @(posedge aclk) begin
        if (conv_wr) conv_mem[conv_len_reg[CI-1:0]] <= conv_ch;
        conv_rd_reg <= conv_mem[conv_raddr[CI-1:0]];
    end

    assign wlen = dec_reg ? XW'(conv_len_reg) : XW'(len_reg);
    assign nlen = dec_reg ? XW'(len_reg) : XW'(conv_len_reg);
    assign sts.word_done = idx_reg >= wlen;
    assign sts.pad_done = col_reg >= PW'(PAD_COLUMN);
    assign sts.num_done = idx_reg >= nlen && !comma_reg;

    assign word_ch = dec_reg ? conv_rd_reg : line_rd_reg;
    assign num_ch = dec_reg ? line_rd_reg : conv_rd_reg;

    always_comb begin
        emit_ch = 1'b0;
        emit_d = bb26_pkg::CH_SPACE;
        if (cmd.emit_word && !sts.word_done) begin
            emit_ch = 1'b1; emit_d = word_ch;
        end else if (cmd.emit_pad && !sts.pad_done) begin
            emit_ch = 1'b1;
        end else if (cmd.emit_num && !sts.num_done) begin
            emit_ch = 1'b1;
            emit_d = comma_reg ? bb26_pkg::CH_COMMA : num_ch;
        end
    end

    // lead group size = len mod 3 (or 3)
    assign lead_prod = 16'(nlen) * 16'(bb26_pkg::RECIP_3);
    assign lead_q = XW'(lead_prod[15:bb26_pkg::RECIP3_SHIFT]);
    assign lead_m = nlen - ((lead_q << 1) + lead_q);
    assign lead = (lead_m == '0) ? 2'd3 : lead_m[1:0];

    // index moves ahead of the registered memory reads
    always_comb begin
        idx_next = idx_reg;
        if (cmd.start_line) idx_next = '0;
        else if (cmd.acc_step && !sts.acc_done) idx_next = idx_reg + 1'b1;
        else if (cmd.conv_step && sts.conv_done) idx_next = '0;
        else if (cmd.emit_word && !sts.word_done) idx_next = idx_reg + 1'b1;
        else if (cmd.emit_pad && sts.pad_done) idx_next = '0;
        else if (cmd.emit_num && !sts.num_done && !comma_reg) idx_next = idx_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.start_line) begin
            len_reg <= line_len_reg;
            dec_reg <= (line_len_reg == '0) || first_reg < bb26_pkg::CH_LA;
            acc_reg <= '0;
            conv_len_reg <= '0;
            chunk_reg <= HW'(NCH - 1);
            rem_reg <= '0;
            busy_reg <= 1'b0;
            borrow_reg <= 1'b0;
        end else if (cmd.acc_step) begin
            if (!sts.acc_done) acc_reg <= AW'(acc_sum);
        end else if (cmd.conv_step) begin
            if (borrow_reg) begin
                acc_reg <= acc_reg - 1'b1;
                borrow_reg <= 1'b0;
            end else if (!sts.conv_done) begin
                acc_reg[{chunk_reg, 4'b0000} +: 16] <= div_q;
                if (chunk_reg == '0) begin
                    chunk_reg <= HW'(NCH - 1);
                    rem_reg <= '0;
                    busy_reg <= 1'b0;
                    conv_len_reg <= conv_len_reg + 1'b1;
                    borrow_reg <= dec_reg && div_rem == '0;
                end else begin
                    chunk_reg <= chunk_reg - 1'b1;
                    rem_reg <= div_rem;
                    busy_reg <= 1'b1;
                end
            end else begin
                cnt_reg <= '0;
            end
        end else if (cmd.emit_word) begin
            if (sts.word_done)
                col_reg <= PW'(wlen > XW'(PAD_COLUMN) ? XW'(PAD_COLUMN) : wlen);
        end else if (cmd.emit_pad) begin
            if (!sts.pad_done) col_reg <= col_reg + 1'b1;
            else begin
                grp_reg <= lead;
                comma_reg <= 1'b0;
            end
        end else if (cmd.emit_num && !sts.num_done) begin
            if (comma_reg) comma_reg <= 1'b0;
            else begin
                if (grp_reg == 2'd1) begin
                    grp_reg <= 2'd3;
                    comma_reg <= (idx_reg + 1'b1) < nlen;
                end else grp_reg <= grp_reg - 1'b1;
            end
        end
        if (emit_ch && cnt_reg < 6'(bb26_pkg::MAX_CHARS)) cnt_reg <= cnt_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) ov_reg <= 1'b0;
        else if (cmd.emit_end || (emit_ch && cnt_reg < 6'(bb26_pkg::MAX_CHARS)))
            ov_reg <= 1'b1;
        else if (m_ready) ov_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_end) begin
            od_reg <= bb26_pkg::CH_NL; ol_reg <= 1'b1;
        end else if (emit_ch && cnt_reg < 6'(bb26_pkg::MAX_CHARS)) begin
            od_reg <= emit_d; ol_reg <= 1'b0;
        end
    end

endmodule

// ----- rtl/core/bijective_base26_decimal_converter.sv -----
// Line converter between decimal and bijective base-26 (a=1 .. z=26).
// Characters are taken one per cycle while collecting; an ordinary character
// is stored and produces nothing. On newline the line is accumulated (one
// stored character per cycle), then converted: each divide-by-10 or -26 digit
// takes one step per 16-bit accumulator chunk, a z digit one more step for its
// borrow, up to 40 digits. Output is emitted one character per cycle while the
// receiver is ready, apart from phase changes: word, spaces to PAD_COLUMN,
// comma-grouped decimal, newline (at most 61 transfers). A line starting with
// '*' is dropped when its newline arrives. Input is not accepted while a line
// is being accumulated, converted or emitted.
module bijective_base26_decimal_converter #(
    parameter int unsigned LINE_DEPTH = 32,
    parameter int unsigned PAD_COLUMN = 22,
    parameter int unsigned ACC_BITS   = 128
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_last_of_line
);

    bb26_pkg::cmd_t    cmd;
    bb26_pkg::status_t sts;
    logic              out_free;
    logic              in_fire;

    assign in_fire = s_valid && s_ready;

    bb26_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_is_nl (s_in_char == bb26_pkg::CH_NL),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (s_ready)
    );

    bb26_dp #(
        .LINE_DEPTH (LINE_DEPTH),
        .PAD_COLUMN (PAD_COLUMN),
        .ACC_BITS   (ACC_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .in_char        (s_in_char),
        .sts            (sts),
        .out_free       (out_free),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_out_char     (m_out_char),
        .m_last_of_line (m_last_of_line)
    );

    // newline output always closes the line
    a_last_nl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_of_line |-> m_out_char == bb26_pkg::CH_NL)
        else $error("last flag without newline");

    // no input while the word or the number of a line is being emitted
    a_no_in: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_word || cmd.emit_num |-> !s_ready)
        else $error("input accepted during emit");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.acc_step, cmd.conv_step, cmd.emit_word, cmd.emit_pad,
                  cmd.emit_num, cmd.emit_end}))
        else $error("conflicting commands");

endmodule

// ----- tb/bb26_line_checker.sv -----
module bb26_line_checker #(
    parameter int unsigned LINE_DEPTH = 32,
    parameter int unsigned PAD_COLUMN = 22
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_in_char,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_char,
    input  logic       m_last_of_line,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } out_char_t;

    out_char_t      expected_chars[$];
    logic [7:0]     line_buf[LINE_DEPTH];
    int unsigned    line_len;
    int unsigned    line_emitted;

    assign pending = expected_chars.size();

    // output line is capped at MAX_CHARS characters plus the closing newline
    function automatic void put_char(logic [7:0] c);
        out_char_t e;
        if (line_emitted < bb26_pkg::MAX_CHARS) begin
            e.ch = c;
            e.last = 1'b0;
            expected_chars.push_back(e);
            line_emitted++;
        end
    endfunction

    function automatic void format_line();
        logic [127:0] acc;
        logic [7:0]   conv[bb26_pkg::CONV_DEPTH];
        int unsigned  conv_len;
        int unsigned  n;
        int unsigned  lead;
        logic [7:0]   first;
        logic [7:0]   r;
        out_char_t    e;
        first = (line_len != 0) ? line_buf[0] : bb26_pkg::CH_NL;
        acc = '0;
        conv_len = 0;
        line_emitted = 0;
        n = line_len;
        line_len = 0;
        if (first == bb26_pkg::CH_STAR)
            return;
        if (first < bb26_pkg::CH_LA) begin
            for (int i = 0; i < n; i++)
                acc = acc * 10 + line_buf[i] - bb26_pkg::CH_ZERO;
            while (acc != 0 && conv_len < bb26_pkg::CONV_DEPTH) begin
                r = 8'(acc % 26);
                acc = acc / 26;
                if (r == 0) begin
                    conv[conv_len++] = bb26_pkg::CH_LZ;
                    acc = acc - 1;
                end else begin
                    conv[conv_len++] = bb26_pkg::CH_LA - 8'd1 + r;
                end
            end
            for (int i = 0; i < conv_len; i++)
                put_char(conv[conv_len - 1 - i]);
            for (int i = conv_len; i < PAD_COLUMN; i++)
                put_char(bb26_pkg::CH_SPACE);
            lead = n % 3;
            for (int i = 0; i < n; i++) begin
                if (i != 0 && i % 3 == lead)
                    put_char(bb26_pkg::CH_COMMA);
                put_char(line_buf[i]);
            end
        end else begin
            for (int i = 0; i < n; i++)
                acc = acc * 26 + line_buf[i] - (bb26_pkg::CH_LA - 8'd1);
            while (acc != 0 && conv_len < bb26_pkg::CONV_DEPTH) begin
                conv[conv_len++] = bb26_pkg::CH_ZERO + 8'(acc % 10);
                acc = acc / 10;
            end
            for (int i = 0; i < n; i++)
                put_char(line_buf[i]);
            for (int i = n; i < PAD_COLUMN; i++)
                put_char(bb26_pkg::CH_SPACE);
            lead = conv_len % 3;
            for (int i = 0; i < conv_len; i++) begin
                if (i != 0 && i % 3 == lead)
                    put_char(bb26_pkg::CH_COMMA);
                put_char(conv[conv_len - 1 - i]);
            end
        end
        e.ch = bb26_pkg::CH_NL;
        e.last = 1'b1;
        expected_chars.push_back(e);
    endfunction

    always @(posedge aclk) begin
        out_char_t e;
        int        errs;
        errs = 0;
        if (!aresetn) begin
            line_len = 0;
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_in_char == bb26_pkg::CH_NL)
                    format_line();
                else if (line_len < LINE_DEPTH)
                    line_buf[line_len++] = s_in_char;
            end
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected transfer: out_char %0d last %0b",
                           m_out_char, m_last_of_line);
                    errs++;
                end else begin
                    e = expected_chars.pop_front();
                    if (m_out_char !== e.ch) begin
                        $error("out_char: expected %0d actual %0d", e.ch, m_out_char);
                        errs++;
                    end
                    if (m_last_of_line !== e.last) begin
                        $error("last_of_line: expected %0b actual %0b",
                               e.last, m_last_of_line);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end

endmodule

// ----- tb/tb_bijective_base26_decimal_converter.sv -----
module tb_bijective_base26_decimal_converter;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_char = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_char;
    logic       m_last_of_line;

    int fail_count;
    int pending;
    int chars_sent = 0;
    int burst_left = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    bijective_base26_decimal_converter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_char     (s_in_char),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_last_of_line(m_last_of_line)
    );

    bb26_line_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_char     (s_in_char),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_last_of_line(m_last_of_line),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Receiver back-pressure: mode is re-rolled at a regular interval so stalls
    // land on the word, pad, number and newline phases alike.
    int rx_mode = 0;
    int rx_tick = 0;
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 64 == 0)
            rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: m_ready <= 1'b1;                              // no stalls
            1: m_ready <= ($urandom_range(0, 3) != 0);       // light stalls
            2: m_ready <= ($urandom_range(0, 1) != 0);       // heavy stalls
            default: m_ready <= ((rx_tick / 5) % 3 != 0);    // periodic stalls
        endcase
    end

    // One transfer on the input channel. Valid stays high across a burst;
    // between bursts it sometimes drops for a random gap.
    task automatic send_char(logic [7:0] c);
        s_valid <= 1'b1;
        s_in_char <= c;
        do @(posedge aclk); while (!s_ready);
        chars_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    endtask

    task automatic send_text(string t);
        for (int i = 0; i < t.len(); i++)
            send_char(t[i]);
        send_char(bb26_pkg::CH_NL);
    endtask

    // Random line: mostly well-formed decimal or letter words, some star
    // lines, some with stray bytes mixed in; lengths sometimes exceed the store.
    task automatic send_random_line();
        int kind;
        int n;
        logic [7:0] c;
        kind = $urandom_range(0, 9);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 14);
        if (kind == 9)
            send_char(bb26_pkg::CH_STAR);
        for (int i = 0; i < n; i++) begin
            if (kind <= 3)
                c = bb26_pkg::CH_ZERO + 8'($urandom_range(0, 9));
            else if (kind <= 7)
                c = bb26_pkg::CH_LA + 8'($urandom_range(0, 25));
            else
                c = 8'($urandom_range(0, 255));
            // a stray newline would split the line; keep noise lines whole
            if (c == bb26_pkg::CH_NL)
                c = 8'd11;
            send_char(c);
        end
        send_char(bb26_pkg::CH_NL);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty line, star line, small values on both sides,
        // the z borrow, overlong lines, wrap of the accumulator, stray bytes
        send_text("");
        send_text("*skip 123");
        send_text("0");
        send_text("1");
        send_text("a");
        send_text("26");
        send_text("z");
        send_text("27");
        send_text("az");
        send_text("1234567");
        send_text("zzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzz");
        send_text("999999999999999999999999999999999999");
        send_text("340282366920938463463374607431768211455");
        send_text("abcdefghijklmnopqrstuvwxyz");
        send_char(8'd255);
        send_char(8'd0);
        send_char(8'd128);
        send_char(8'd127);
        send_char(bb26_pkg::CH_NL);
        send_text("a{~");
        send_text("-5");
        send_text("*");
        send_text("*a");
        send_text("b");

        while (chars_sent < 500)
            send_random_line();
        s_valid <= 1'b0;

        while (pending != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule
